FILE: rtl/vpa_pkg.sv
// vpa_pkg: shared types, field widths and codes for the vcpu to pcpu allocator
// used by the channel interfaces and every module of the block

package vpa_pkg;

   localparam int NUM_CPUS_DEF = 8;
   localparam int SLOTS_DEF    = 2;

   localparam int KindW    = 2;
   localparam int VmW      = 4;
   localparam int VcW      = 4;
   localparam int CpuFldW  = 3;
   localparam int ReqW     = 4;
   localparam int AvailW   = 4;
   localparam int NonrtW   = 3;
   localparam int MaxPcW   = 2;
   localparam int CapW     = 2;
   localparam int LoadW    = 2;
   localparam int CsrIdxW  = 1;
   localparam int CsrDataW = 3;

   localparam logic [KindW-1:0] KIND_ALLOC   = 2'd0;
   localparam logic [KindW-1:0] KIND_RELEASE = 2'd1;
   localparam logic [KindW-1:0] KIND_CHECK   = 2'd2;

   localparam logic [CsrIdxW-1:0] CSR_NONRT_COUNT = 1'd0;
   localparam logic [CsrIdxW-1:0] CSR_MAX_PER_CPU = 1'd1;

   localparam logic [NonrtW-1:0] RST_NONRT_COUNT = 3'd3;
   localparam logic [MaxPcW-1:0] RST_MAX_PER_CPU = 2'd2;

   localparam logic [CapW-1:0]   CAP_ONE   = 2'd1;
   localparam logic [CapW-1:0]   CAP_TWO   = 2'd2;
   localparam logic [AvailW-1:0] AVAIL_MAX = 4'd15;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [KindW-1:0]   kind;
      logic               is_rtos;
      logic [VmW-1:0]     vm_id;
      logic [VcW-1:0]     vcpu_id;
      logic [CpuFldW-1:0] release_cpu;
      logic [ReqW-1:0]    requested;
   } req_type;

   typedef struct packed {
      logic               ok;
      logic [CpuFldW-1:0] cpu;
      logic [AvailW-1:0]  available;
   } rsp_type;

   typedef struct packed {
      logic [VmW-1:0] vm;
      logic [VcW-1:0] vc;
   } slot_type;

   typedef struct packed {
      logic [VmW-1:0]  vm;
      logic [VcW-1:0]  vc;
      logic [CapW-1:0] cap;
   } eval_ctl_type;

   typedef struct packed {
      logic empty;
      logic half_other;
      logic has_room;
      logic match_hit;
      logic match_slot;
      logic free_slot;
   } eval_type;

   typedef struct packed {
      logic           wr_en;
      logic           set_valid;
      logic           slot;
      logic [VmW-1:0] vm;
      logic [VcW-1:0] vc;
   } store_cmd_type;

endpackage

FILE: rtl/vpa_req_if.sv
// vpa_req_if: request channel carrying one allocator item
// depends on vpa_pkg for field widths

interface vpa_req_if;
   import vpa_pkg::*;

   logic               valid;
   logic               ready;
   logic [KindW-1:0]   kind;
   logic               is_rtos;
   logic [VmW-1:0]     vm_id;
   logic [VcW-1:0]     vcpu_id;
   logic [CpuFldW-1:0] release_cpu;
   logic [ReqW-1:0]    requested;

   modport source (
      output valid, kind, is_rtos, vm_id, vcpu_id, release_cpu, requested,
      input  ready
   );

   modport sink (
      input  valid, kind, is_rtos, vm_id, vcpu_id, release_cpu, requested,
      output ready
   );
endinterface

FILE: rtl/vpa_rsp_if.sv
// vpa_rsp_if: response channel carrying one allocator result item
// depends on vpa_pkg for field widths

interface vpa_rsp_if;
   import vpa_pkg::*;

   logic               valid;
   logic               ready;
   logic               ok;
   logic [CpuFldW-1:0] cpu;
   logic [AvailW-1:0]  available;

   modport source (
      output valid, ok, cpu, available,
      input  ready
   );

   modport sink (
      input  valid, ok, cpu, available,
      output ready
   );
endinterface

FILE: rtl/vpa_slot_store.sv
// vpa_slot_store: per-cpu slot rows with valid flags, one registered row read
// and one slot write per cycle; depends on vpa_pkg

module vpa_slot_store #(
   parameter int NUM_CPUS      = vpa_pkg::NUM_CPUS_DEF,
   parameter int SLOTS_PER_CPU = vpa_pkg::SLOTS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [$clog2(NUM_CPUS)-1:0] rd_row,
   input  logic [$clog2(NUM_CPUS)-1:0] wr_row,
   input  vpa_pkg::store_cmd_type      cmd,
   output logic [SLOTS_PER_CPU-1:0]    rd_valid,
   output vpa_pkg::slot_type           rd_ent [SLOTS_PER_CPU]
);
   import vpa_pkg::*;

   logic [SLOTS_PER_CPU-1:0] valid_ff [NUM_CPUS];
   slot_type                 mem_ff [NUM_CPUS][SLOTS_PER_CPU];
   logic [SLOTS_PER_CPU-1:0] rd_valid_ff;
   slot_type                 rd_ent_ff [SLOTS_PER_CPU];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NUM_CPUS; c++) begin
            valid_ff[c] <= '0;
         end
      end else if (cmd.wr_en) begin
         for (int s = 0; s < SLOTS_PER_CPU; s++) begin
            if (cmd.slot == 1'(s)) begin
               valid_ff[wr_row][s] <= cmd.set_valid;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en && cmd.set_valid) begin
         for (int s = 0; s < SLOTS_PER_CPU; s++) begin
            if (cmd.slot == 1'(s)) begin
               mem_ff[wr_row][s] <= '{vm: cmd.vm, vc: cmd.vc};
            end
         end
      end
      rd_valid_ff <= valid_ff[rd_row];
      for (int s = 0; s < SLOTS_PER_CPU; s++) begin
         rd_ent_ff[s] <= mem_ff[rd_row][s];
      end
   end

   assign rd_valid = rd_valid_ff;
   assign rd_ent   = rd_ent_ff;

endmodule

FILE: rtl/vpa_cpu_eval.sv
// vpa_cpu_eval: shared per-cpu evaluation unit, applied to one slot row a cycle
// reports load class, room, release match and free slot; depends on vpa_pkg

module vpa_cpu_eval #(
   parameter int SLOTS_PER_CPU = vpa_pkg::SLOTS_DEF
) (
   input  logic [SLOTS_PER_CPU-1:0] row_valid,
   input  vpa_pkg::slot_type        row_ent [SLOTS_PER_CPU],
   input  vpa_pkg::eval_ctl_type    ctl,
   output vpa_pkg::eval_type        ev
);
   import vpa_pkg::*;

   logic [LoadW-1:0] load;
   logic             holds_vm;
   logic             free_hit;

   always_comb begin
      load     = '0;
      holds_vm = 1'b0;
      free_hit = 1'b0;
      ev       = '0;
      for (int s = 0; s < SLOTS_PER_CPU; s++) begin
         if (row_valid[s]) begin
            load = load + LoadW'(1);
            if (row_ent[s].vm == ctl.vm) begin
               holds_vm = 1'b1;
               if (row_ent[s].vc == ctl.vc && !ev.match_hit) begin
                  ev.match_hit  = 1'b1;
                  ev.match_slot = 1'(s);
               end
            end
         end else if (!free_hit) begin
            free_hit     = 1'b1;
            ev.free_slot = 1'(s);
         end
      end
      ev.empty      = (load == '0);
      ev.half_other = (load == LoadW'(1)) && !holds_vm;
      ev.has_room   = (load < ctl.cap);
   end

endmodule

FILE: rtl/vpa_seq.sv
// vpa_seq: sequencer that walks the cpus of a domain through the eval unit,
// resolves the choice, writes the slot store and holds the result item; uses vpa_pkg

module vpa_seq #(
   parameter int NUM_CPUS      = vpa_pkg::NUM_CPUS_DEF,
   parameter int SLOTS_PER_CPU = vpa_pkg::SLOTS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  vpa_pkg::req_type             req,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output vpa_pkg::rsp_type             rsp,
   input  logic [vpa_pkg::NonrtW-1:0]   nonrt_count,
   input  logic [vpa_pkg::MaxPcW-1:0]   max_per_cpu,
   output logic [$clog2(NUM_CPUS)-1:0]  rd_row,
   output vpa_pkg::eval_ctl_type        ctl,
   input  vpa_pkg::eval_type            ev,
   output logic [$clog2(NUM_CPUS)-1:0]  wr_row,
   output vpa_pkg::store_cmd_type       cmd
);
   import vpa_pkg::*;

   localparam int CpuW  = $clog2(NUM_CPUS);
   localparam int CntW  = $clog2(NUM_CPUS + 1);
   localparam int EdgeW = (CntW > 4) ? CntW : 4;

   state_type       state_ff, state_in;
   req_type         item_ff, item_in;
   logic [CpuW-1:0] idx_ff, idx_in;
   logic [CpuW-1:0] last_ff, last_in;
   logic            issue_on_ff, issue_on_in;
   logic            eval_vld_ff, eval_vld_in;
   logic [CpuW-1:0] eval_idx_ff, eval_idx_in;
   logic            got_empty_ff, got_empty_in;
   logic [CpuW-1:0] empty_idx_ff, empty_idx_in;
   logic            got_half_ff, got_half_in;
   logic [CpuW-1:0] half_idx_ff, half_idx_in;
   logic            half_slot_ff, half_slot_in;
   logic            got_match_ff, got_match_in;
   logic            match_slot_ff, match_slot_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_ff, rsp_in;

   logic [EdgeW-1:0] edge_raw, edge_cl, dom_lo, dom_hi, dom_last;
   logic             dom_busy, rel_in_range;
   logic [CapW-1:0]  cap_nonrt;
   logic             use_empty, use_half;
   logic [CpuW-1:0]  chosen;
   rsp_type          res;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issue_on_ff  <= 1'b0;
         eval_vld_ff  <= 1'b0;
         got_empty_ff <= 1'b0;
         got_half_ff  <= 1'b0;
         got_match_ff <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issue_on_ff  <= issue_on_in;
         eval_vld_ff  <= eval_vld_in;
         got_empty_ff <= got_empty_in;
         got_half_ff  <= got_half_in;
         got_match_ff <= got_match_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff       <= item_in;
      idx_ff        <= idx_in;
      last_ff       <= last_in;
      eval_idx_ff   <= eval_idx_in;
      empty_idx_ff  <= empty_idx_in;
      half_idx_ff   <= half_idx_in;
      half_slot_ff  <= half_slot_in;
      match_slot_ff <= match_slot_in;
      rsp_ff        <= rsp_in;
   end

   // domain bounds of the incoming item
   always_comb begin
      edge_raw     = EdgeW'(nonrt_count) + EdgeW'(1);
      edge_cl      = (edge_raw > EdgeW'(NUM_CPUS)) ? EdgeW'(NUM_CPUS) : edge_raw;
      dom_lo       = req.is_rtos ? edge_cl : EdgeW'(1);
      dom_hi       = req.is_rtos ? EdgeW'(NUM_CPUS) : edge_cl;
      dom_last     = dom_hi - EdgeW'(1);
      dom_busy     = (dom_lo < dom_hi);
      rel_in_range = (EdgeW'(req.release_cpu) < EdgeW'(NUM_CPUS));
      cap_nonrt    = (SLOTS_PER_CPU == 2 && max_per_cpu >= CAP_TWO) ? CAP_TWO : CAP_ONE;
   end

   // resolution of the finished scan
   always_comb begin
      use_empty = got_empty_ff;
      use_half  = !got_empty_ff && got_half_ff && !item_ff.is_rtos && (cap_nonrt == CAP_TWO);
      chosen    = use_empty ? empty_idx_ff : half_idx_ff;
      res       = '0;
      case (item_ff.kind)
         KIND_ALLOC: begin
            res.ok  = use_empty || use_half;
            res.cpu = (use_empty || use_half) ? CpuFldW'(chosen) : '0;
         end
         KIND_RELEASE: begin
            res.ok = 1'b1;
         end
         KIND_CHECK: begin
            res.ok        = (EdgeW'(item_ff.requested) <= EdgeW'(cnt_ff));
            res.available = (EdgeW'(cnt_ff) > EdgeW'(AVAIL_MAX)) ? AVAIL_MAX
                                                                 : AvailW'(cnt_ff);
         end
         default: begin
            res = '0;
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      item_in       = item_ff;
      idx_in        = idx_ff;
      last_in       = last_ff;
      issue_on_in   = issue_on_ff;
      eval_vld_in   = 1'b0;
      eval_idx_in   = eval_idx_ff;
      got_empty_in  = got_empty_ff;
      empty_idx_in  = empty_idx_ff;
      got_half_in   = got_half_ff;
      half_idx_in   = half_idx_ff;
      half_slot_in  = half_slot_ff;
      got_match_in  = got_match_ff;
      match_slot_in = match_slot_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_in        = rsp_ff;
      req_ready     = 1'b0;
      cmd           = '0;
      wr_row        = chosen;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               item_in      = req;
               got_empty_in = 1'b0;
               got_half_in  = 1'b0;
               got_match_in = 1'b0;
               cnt_in       = '0;
               state_in     = ST_FINISH;
               case (req.kind) inside
                  KIND_ALLOC, KIND_CHECK: begin
                     if (dom_busy) begin
                        idx_in      = CpuW'(dom_lo);
                        last_in     = CpuW'(dom_last);
                        issue_on_in = 1'b1;
                        state_in    = ST_SCAN;
                     end
                  end
                  KIND_RELEASE: begin
                     if (rel_in_range) begin
                        idx_in      = CpuW'(req.release_cpu);
                        last_in     = CpuW'(req.release_cpu);
                        issue_on_in = 1'b1;
                        state_in    = ST_SCAN;
                     end
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end

         ST_SCAN: begin
            if (issue_on_ff) begin
               eval_vld_in = 1'b1;
               eval_idx_in = idx_ff;
               if (idx_ff == last_ff) begin
                  issue_on_in = 1'b0;
               end else begin
                  idx_in = idx_ff + CpuW'(1);
               end
            end
            if (eval_vld_ff) begin
               case (item_ff.kind)
                  KIND_ALLOC: begin
                     if (ev.empty && !got_empty_ff) begin
                        got_empty_in = 1'b1;
                        empty_idx_in = eval_idx_ff;
                     end
                     if (ev.half_other && !got_half_ff) begin
                        got_half_in  = 1'b1;
                        half_idx_in  = eval_idx_ff;
                        half_slot_in = ev.free_slot;
                     end
                  end
                  KIND_CHECK: begin
                     if (ev.has_room) begin
                        cnt_in = cnt_ff + CntW'(1);
                     end
                  end
                  KIND_RELEASE: begin
                     got_match_in  = ev.match_hit;
                     match_slot_in = ev.match_slot;
                  end
                  default: begin
                     cnt_in = cnt_ff;
                  end
               endcase
               if (eval_idx_ff == last_ff) begin
                  eval_vld_in = 1'b0;
                  state_in    = ST_FINISH;
               end
            end
         end

         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_in       = res;
               state_in     = ST_IDLE;
               if (item_ff.kind == KIND_ALLOC && (use_empty || use_half)) begin
                  cmd.wr_en     = 1'b1;
                  cmd.set_valid = 1'b1;
                  cmd.slot      = use_empty ? 1'b0 : half_slot_ff;
                  cmd.vm        = item_ff.vm_id;
                  cmd.vc        = item_ff.vcpu_id;
                  wr_row        = chosen;
               end else if (item_ff.kind == KIND_RELEASE && got_match_ff) begin
                  cmd.wr_en     = 1'b1;
                  cmd.set_valid = 1'b0;
                  cmd.slot      = match_slot_ff;
                  wr_row        = last_ff;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rd_row    = idx_ff;
   assign ctl.vm    = item_ff.vm_id;
   assign ctl.vc    = item_ff.vcpu_id;
   assign ctl.cap   = item_ff.is_rtos ? CAP_ONE : cap_nonrt;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   a_write_only_at_finish: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_en |-> state_ff == ST_FINISH)
      else $error("slot store written outside finish");

   a_scan_has_work: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> (issue_on_ff || eval_vld_ff))
      else $error("scan state with nothing issued or pending");

   a_never_place_cpu0: assert property (@(posedge clock) disable iff (reset)
      (cmd.wr_en && cmd.set_valid) |-> wr_row != '0)
      else $error("vcpu placed on reserved cpu 0");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CntW'(NUM_CPUS - 1))
      else $error("room count exceeds cpu count");

endmodule

FILE: rtl/vcpu_to_pcpu_allocator_unit.sv
// vcpu_to_pcpu_allocator_unit: places vcpus on physical cpus, one item at a time
// the scan covers n cpus, n = the domain size for allocate and check, 1 for release;
//   with nothing to scan the item goes straight to finish
// items pass one at a time through the single shared cpu eval unit
//   that sees one registered slot row per cycle; the next item may enter while a result waits
// reset: all slots empty, nonrt_cpu_count 3, max_per_cpu 2; no clearing pass

module vcpu_to_pcpu_allocator_unit #(
   parameter int NUM_CPUS      = vpa_pkg::NUM_CPUS_DEF,
   parameter int SLOTS_PER_CPU = vpa_pkg::SLOTS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   vpa_req_if.sink                       req_chan,
   vpa_rsp_if.source                     rsp_chan,
   input  logic                          csr_we,
   input  logic [vpa_pkg::CsrIdxW-1:0]   csr_index,
   input  logic [vpa_pkg::CsrDataW-1:0]  csr_wdata
);
   import vpa_pkg::*;

   localparam int CpuW = $clog2(NUM_CPUS);

   logic [NonrtW-1:0] nonrt_ff;
   logic [MaxPcW-1:0] max_pc_ff;

   req_type                  req_item;
   rsp_type                  rsp_item;
   logic [CpuW-1:0]          rd_row, wr_row;
   store_cmd_type            cmd;
   eval_ctl_type             ctl;
   eval_type                 ev;
   logic [SLOTS_PER_CPU-1:0] row_valid;
   slot_type                 row_ent [SLOTS_PER_CPU];

   always_ff @(posedge clock) begin
      if (reset) begin
         nonrt_ff  <= RST_NONRT_COUNT;
         max_pc_ff <= RST_MAX_PER_CPU;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_NONRT_COUNT: nonrt_ff  <= csr_wdata;
            CSR_MAX_PER_CPU: max_pc_ff <= csr_wdata[MaxPcW-1:0];
            default: begin
               nonrt_ff <= nonrt_ff;
            end
         endcase
      end
   end

   assign req_item.kind        = req_chan.kind;
   assign req_item.is_rtos     = req_chan.is_rtos;
   assign req_item.vm_id       = req_chan.vm_id;
   assign req_item.vcpu_id     = req_chan.vcpu_id;
   assign req_item.release_cpu = req_chan.release_cpu;
   assign req_item.requested   = req_chan.requested;

   assign rsp_chan.ok        = rsp_item.ok;
   assign rsp_chan.cpu       = rsp_item.cpu;
   assign rsp_chan.available = rsp_item.available;

   vpa_seq #(
      .NUM_CPUS      (NUM_CPUS),
      .SLOTS_PER_CPU (SLOTS_PER_CPU)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_ready   (req_chan.ready),
      .req         (req_item),
      .rsp_valid   (rsp_chan.valid),
      .rsp_ready   (rsp_chan.ready),
      .rsp         (rsp_item),
      .nonrt_count (nonrt_ff),
      .max_per_cpu (max_pc_ff),
      .rd_row      (rd_row),
      .ctl         (ctl),
      .ev          (ev),
      .wr_row      (wr_row),
      .cmd         (cmd)
   );

   vpa_slot_store #(
      .NUM_CPUS      (NUM_CPUS),
      .SLOTS_PER_CPU (SLOTS_PER_CPU)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .rd_row   (rd_row),
      .wr_row   (wr_row),
      .cmd      (cmd),
      .rd_valid (row_valid),
      .rd_ent   (row_ent)
   );

   vpa_cpu_eval #(
      .SLOTS_PER_CPU (SLOTS_PER_CPU)
   ) u_eval (
      .row_valid (row_valid),
      .row_ent   (row_ent),
      .ctl       (ctl),
      .ev        (ev)
   );

endmodule
